// ----- sv/utf8sv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream validator package
// Transaction types, result grouping and byte constants shared by the
// validator modules.
// ----------------------------------------------------------------------------
package utf8sv_pkg;

    // Most result transactions that one input byte can cause.
    localparam int MAX_RESULTS = 4;
    // Width of a count of result transactions, zero through MAX_RESULTS.
    localparam int PUSH_W = $clog2(MAX_RESULTS + 1);
    // Bytes of an incomplete sequence that can be carried between inputs.
    localparam int HOLD_DEPTH = 3;

    // Result queue size. The pointers wrap naturally, so this stays a power
    // of two, and it holds at least two worst-case bursts of MAX_RESULTS.
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_TAG       = 8'h80;
    localparam logic [7:0] LEAD_TWO_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_THREE_MIN = 8'hE0;
    localparam logic [7:0] LEAD_FOUR_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_BAD_MIN   = 8'hF5;
    localparam logic [7:0] LEAD_E0        = 8'hE0;
    localparam logic [7:0] LEAD_ED        = 8'hED;
    localparam logic [7:0] LEAD_F0        = 8'hF0;
    localparam logic [7:0] LEAD_F4        = 8'hF4;
    localparam logic [7:0] E0_SECOND_MIN  = 8'hA0;
    localparam logic [7:0] ED_SECOND_MAX  = 8'h9F;
    localparam logic [7:0] F0_SECOND_MIN  = 8'h90;
    localparam logic [7:0] F4_SECOND_MAX  = 8'h8F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_stream;
    } t_out_item;

    // Everything the scan of one input byte produces.
    typedef struct packed {
        logic [PUSH_W-1:0]                    push_count;
        t_out_item [MAX_RESULTS-1:0]          items;
        logic [1:0]                           held_count;
        logic [HOLD_DEPTH-1:0][7:0]           held_bytes;
    } t_scan_result;

endpackage
`default_nettype wire

// ----- sv/utf8_stream_validator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Filters a byte stream down to well-formed UTF-8 and marks its end.
// ----------------------------------------------------------------------------
// Usage: raw bytes enter on the input channel (i_in_valid, i_in_item,
// o_in_stall), one byte per transaction with its last flag. Kept bytes
// leave on the output channel (o_out_valid, o_out_item, i_out_stall), one
// per transaction, in stream order. A stream that ends with nothing kept
// gives a single bare end marker with byte_present low.
// Throughput: one input byte per cycle while the queue has room. The rate
// is set by the single-pass scan of the held bytes plus the new byte, which
// updates the held state each time a byte is scanned; the result queue
// drains one transaction per cycle while the receiver does not stall.
// An accepted byte is held in the input register and scanned from there;
// its results are written into the result queue and offered from its head.
// Reset clears the input register, the held count and the queue pointers.
// When the receiver stalls, results collect in the queue (QUEUE_DEPTH
// entries); a byte is scanned only while the queue has room for four more
// results, otherwise it waits in the input register and o_in_stall rises.
// ----------------------------------------------------------------------------
module utf8_stream_validator_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire utf8sv_pkg::t_in_item  i_in_item,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output utf8sv_pkg::t_out_item      o_out_item,
    input  wire logic                  i_out_stall
);
    import utf8sv_pkg::*;

    localparam int CNT_W = QUEUE_CNT_W;

    // Input register: one byte transaction waiting for the scan.
    logic                        r_in_valid;
    logic                        n_in_valid;
    t_in_item                    r_in_item;

    // Bytes of an incomplete sequence carried to the next byte.
    logic [HOLD_DEPTH-1:0][7:0]  r_held;
    logic [1:0]                  r_held_count;

    logic [3:0][7:0]             scan_buf;
    logic [2:0]                  scan_cnt;
    t_scan_result                scan_res;
    logic                        scan_en;
    logic                        in_accept;
    logic                        out_pop;
    logic [CNT_W-1:0]            fifo_count;
    logic [PUSH_W-1:0]           push_count;

    // A byte is scanned only when the queue can absorb its worst case.
    assign scan_en    = r_in_valid && (fifo_count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign o_in_stall = r_in_valid && !scan_en;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign push_count = scan_en ? scan_res.push_count : '0;

    assign o_out_valid = (fifo_count != '0);
    assign out_pop     = o_out_valid && !i_out_stall;

    // Held bytes first, then the new byte right behind them.
    always_comb begin
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            scan_buf[k] = (2'(k) < r_held_count) ? r_held[k] : r_in_item.data_byte;
        end
        scan_buf[3] = r_in_item.data_byte;
        scan_cnt    = {1'b0, r_held_count} + 3'd1;
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept)    n_in_valid = 1'b1;
        else if (scan_en) n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_held_count <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (scan_en) r_held_count <= scan_res.held_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_in_item <= i_in_item;
        if (scan_en)   r_held    <= scan_res.held_bytes;
    end

    utf8sv_scan u_scan (
        .i_buf  (scan_buf),
        .i_cnt  (scan_cnt),
        .i_last (r_in_item.last_byte),
        .o_res  (scan_res)
    );

    utf8sv_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_push_items (scan_res.items),
        .i_pop        (out_pop),
        .o_head       (o_out_item),
        .o_count      (fifo_count)
    );

`ifndef SYNTHESIS
    // A last byte always leaves nothing pending.
    a_last_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_en && r_in_item.last_byte) |=> (r_held_count == 2'd0))
        else $error("held bytes remain after a last byte");

    // A last byte always produces at least one result, the end marker.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_en && r_in_item.last_byte) |-> (scan_res.push_count != '0))
        else $error("last byte produced no result");

    // The held state only moves when a byte is scanned.
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !scan_en |=> $stable(r_held_count))
        else $error("held count changed without a scan");
`endif

endmodule
`default_nettype wire

// ----- sv/utf8sv_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream validator scan
// Scans the held bytes plus the new byte in one pass, marks kept bytes,
// packs them into result transactions and returns the bytes left pending.
// ----------------------------------------------------------------------------
module utf8sv_scan (
    input  wire logic [3:0][7:0]          i_buf,
    input  wire logic [2:0]               i_cnt,
    input  wire logic                     i_last,
    output utf8sv_pkg::t_scan_result      o_res
);
    import utf8sv_pkg::*;

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < CONT_TAG)            len = 3'd1;
        else if (b < LEAD_TWO_MIN)   len = 3'd0;
        else if (b < LEAD_THREE_MIN) len = 3'd2;
        else if (b < LEAD_FOUR_MIN)  len = 3'd3;
        else if (b < LEAD_BAD_MIN)   len = 3'd4;
        else                         len = 3'd0;
        return len;
    endfunction

    function automatic logic single_ok(input logic [7:0] b);
        return (b >= BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_LF) || (b == BYTE_CR);
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic logic multi_ok(input logic [7:0] lead, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [2:0] n);
        logic ok;
        ok = is_cont(b1);
        if (n >= 3'd3 && !is_cont(b2)) ok = 1'b0;
        if (n == 3'd4 && !is_cont(b3)) ok = 1'b0;
        unique case (lead)
            LEAD_E0: if (b1 < E0_SECOND_MIN) ok = 1'b0;
            LEAD_ED: if (b1 > ED_SECOND_MAX) ok = 1'b0;
            LEAD_F0: if (b1 < F0_SECOND_MIN) ok = 1'b0;
            LEAD_F4: if (b1 > F4_SECOND_MAX) ok = 1'b0;
            default: ;
        endcase
        return ok;
    endfunction

    logic [3:0] keep;
    logic [2:0] end_pos;

    // Walk the buffer: at most four steps, each consumes at least one byte.
    always_comb begin : p_walk
        logic [2:0] pos;
        logic       done;
        logic [2:0] n;
        logic [2:0] avail;
        logic [7:0] lead;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        keep = '0;
        pos  = '0;
        done = 1'b0;
        for (int it = 0; it < 4; it++) begin
            lead  = i_buf[pos[1:0]];
            b1    = i_buf[pos[1:0] + 2'd1];
            b2    = i_buf[pos[1:0] + 2'd2];
            b3    = i_buf[pos[1:0] + 2'd3];
            n     = seq_length(lead);
            avail = i_cnt - pos;
            if (!done && (pos < i_cnt)) begin
                if (n == 3'd1) begin
                    if (single_ok(lead)) keep[pos[1:0]] = 1'b1;
                    pos = pos + 3'd1;
                end else if (n == 3'd0) begin
                    pos = pos + 3'd1;
                end else if (avail < n) begin
                    if (!i_last) done = 1'b1;
                    else         pos = pos + 3'd1;
                end else if (multi_ok(lead, b1, b2, b3, n)) begin
                    for (int j = 0; j < 4; j++) begin
                        if ((3'(j) >= pos) && (3'(j) < pos + n)) keep[j] = 1'b1;
                    end
                    pos = pos + n;
                end else begin
                    pos = pos + 3'd1;
                end
            end
        end
        end_pos = pos;
    end

    // Pack kept bytes in order and attach the end marker.
    always_comb begin : p_pack
        logic [3:0][2:0] pre;
        logic [2:0]      idx;
        logic [2:0]      rest;
        o_res = '0;
        idx   = '0;
        for (int j = 0; j < 4; j++) begin
            pre[j] = idx;
            idx    = idx + {2'b00, keep[j]};
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            for (int j = 0; j < 4; j++) begin
                if (keep[j] && (pre[j] == 3'(k))) begin
                    o_res.items[k].out_byte     = i_buf[j];
                    o_res.items[k].byte_present = 1'b1;
                end
            end
        end
        if (i_last) begin
            if (idx == 3'd0) begin
                o_res.items[0].end_of_stream = 1'b1;
                o_res.push_count             = PUSH_W'(1);
            end else begin
                for (int k = 0; k < MAX_RESULTS; k++) begin
                    if (3'(k) == idx - 3'd1) o_res.items[k].end_of_stream = 1'b1;
                end
                o_res.push_count = PUSH_W'(idx);
            end
        end else begin
            o_res.push_count = PUSH_W'(idx);
        end
        // Without a last flag, whatever remains after the walk is pending.
        rest = i_cnt - end_pos;
        if (!i_last) o_res.held_count = rest[1:0];
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            o_res.held_bytes[k] = i_buf[end_pos[1:0] + 2'(k)];
        end
    end

endmodule
`default_nettype wire

// ----- sv/utf8sv_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream validator result queue
// Register queue that takes up to four result transactions per cycle and
// delivers one per cycle from its head while i_pop is high.
// ----------------------------------------------------------------------------
module utf8sv_fifo (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic [utf8sv_pkg::PUSH_W-1:0]                   i_push_count,
    input  wire utf8sv_pkg::t_out_item [utf8sv_pkg::MAX_RESULTS-1:0] i_push_items,
    input  wire logic                                            i_pop,
    output utf8sv_pkg::t_out_item                                o_head,
    output logic [utf8sv_pkg::QUEUE_CNT_W-1:0]                   o_count
);
    import utf8sv_pkg::*;

    localparam int PTR_W = QUEUE_PTR_W;
    localparam int CNT_W = QUEUE_CNT_W;

    t_out_item [QUEUE_DEPTH-1:0] r_mem;
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [PTR_W-1:0]      n_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_count);
        n_rd_ptr = r_rd_ptr + PTR_W'(i_pop);
        n_count  = r_count + CNT_W'(i_push_count) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (PUSH_W'(k) < i_push_count) r_mem[r_wr_ptr + PTR_W'(k)] <= i_push_items[k];
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
`default_nettype wire

// ----- tb/utf8_stream_validator_unit_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream validator testbench
// Drives byte streams into the validator and checks every kept byte and end
// marker against a cycle-free predictor of the filter. A short table of
// corner cases comes first, then random streams that are mostly well-formed
// UTF-8, under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module utf8_stream_validator_unit_tb;

    import utf8sv_pkg::*;

    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Extra cycles after the last expected result, enough to cover the input
    // register, the scan and a full result queue, so any surplus result shows up.
    localparam int DRAIN_CYCLES   = 16;
    // Input bytes per random phase.
    localparam int PHASE_ITEMS    = 50;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES    = 60;
    localparam int REPORT_MAX     = 10;

    localparam t_out_item NO_RESULT = '0;
    localparam t_out_item BARE_END  = '{8'h00, 1'b0, 1'b1};

    // One row of the corner-case table. Where typed is set, want is the only
    // result the row may cause; otherwise the predictor decides.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       typed;
        t_out_item  want;
    } t_dir_row;

    localparam int DIR_N = 26;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        // Plain ASCII right after reset, then rejected bytes at a last flag.
        '{8'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1}},
        '{8'h00, 1'b1, 1'b1, BARE_END},
        '{8'hFF, 1'b1, 1'b1, BARE_END},
        // Highest ASCII byte and the three control bytes that are kept.
        '{8'h7F, 1'b0, 1'b0, NO_RESULT},
        '{8'h09, 1'b0, 1'b0, NO_RESULT},
        '{8'h0A, 1'b0, 1'b0, NO_RESULT},
        '{8'h0D, 1'b0, 1'b0, NO_RESULT},
        '{8'h20, 1'b1, 1'b1, '{8'h20, 1'b1, 1'b1}},
        // Smallest two-byte sequence, then an overlong lead.
        '{8'hC2, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'hC1, 1'b0, 1'b0, NO_RESULT},
        // E0 with a second byte just below its range.
        '{8'hE0, 1'b0, 1'b0, NO_RESULT},
        '{8'h9F, 1'b0, 1'b0, NO_RESULT},
        // ED with a second byte at the top of its range.
        '{8'hED, 1'b0, 1'b0, NO_RESULT},
        '{8'h9F, 1'b0, 1'b0, NO_RESULT},
        '{8'hBF, 1'b0, 1'b0, NO_RESULT},
        // F4 just above its range, completed at a last byte.
        '{8'hF4, 1'b0, 1'b0, NO_RESULT},
        '{8'h90, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b0, NO_RESULT},
        // F0 at the bottom of its range: three bytes held, then four kept.
        '{8'hF0, 1'b0, 1'b0, NO_RESULT},
        '{8'h90, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'hBF, 1'b1, 1'b0, NO_RESULT},
        // A sequence cut short by the end of the stream.
        '{8'hE2, 1'b0, 1'b0, NO_RESULT},
        '{8'h82, 1'b1, 1'b1, BARE_END}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Predictor state: bytes of a sequence still waiting for its tail.
    logic [7:0] held_b [HOLD_DEPTH];
    int         held_n;

    t_out_item  kept_q [$];     // results of the latest scanned byte
    t_out_item  pending_q [$];  // results still owed by the block
    logic [7:0] stream_q [$];   // bytes of the stream being sent

    int send_pct   = 0;
    int stall_pct  = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int idle_cycles = 0;
    int fail_cnt   = 0;

    utf8_stream_validator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Scans the held bytes plus one new byte exactly as the filter does and
    // leaves the kept bytes in kept_q. The held bytes are updated for the
    // next call.
    task automatic predict_kept(input t_in_item it);
        logic [7:0] buf_b [HOLD_DEPTH + 1];
        logic [7:0] lead;
        t_out_item  tail;
        int         cnt, pos, n, k;
        bit         ok, stop;
        kept_q.delete();
        cnt = held_n;
        for (k = 0; k < cnt; k++) begin
            buf_b[k] = held_b[k];
        end
        buf_b[cnt] = it.data_byte;
        cnt++;
        pos  = 0;
        stop = 1'b0;
        while (pos < cnt && !stop) begin
            lead = buf_b[pos];
            // Sequence length from the lead byte; zero marks a byte that
            // can never start a sequence.
            if (lead < CONT_TAG) begin
                n = 1;
            end else if (lead < LEAD_TWO_MIN) begin
                n = 0;
            end else if (lead < LEAD_THREE_MIN) begin
                n = 2;
            end else if (lead < LEAD_FOUR_MIN) begin
                n = 3;
            end else if (lead < LEAD_BAD_MIN) begin
                n = 4;
            end else begin
                n = 0;
            end
            if (n == 1) begin
                if (lead >= BYTE_SPACE || lead == BYTE_TAB || lead == BYTE_LF ||
                    lead == BYTE_CR) begin
                    kept_q.push_back(t_out_item'{lead, 1'b1, 1'b0});
                end
                pos++;
            end else if (n == 0) begin
                pos++;
            end else if (cnt - pos < n) begin
                // Tail not here yet: hold it, unless the stream ends now.
                if (it.last_byte) begin
                    pos++;
                end else begin
                    stop = 1'b1;
                end
            end else begin
                ok = 1'b1;
                for (k = 1; k < n; k++) begin
                    if ((buf_b[pos + k] & CONT_MASK) != CONT_TAG) begin
                        ok = 1'b0;
                    end
                end
                case (lead)
                    LEAD_E0: if (buf_b[pos + 1] < E0_SECOND_MIN) ok = 1'b0;
                    LEAD_ED: if (buf_b[pos + 1] > ED_SECOND_MAX) ok = 1'b0;
                    LEAD_F0: if (buf_b[pos + 1] < F0_SECOND_MIN) ok = 1'b0;
                    LEAD_F4: if (buf_b[pos + 1] > F4_SECOND_MAX) ok = 1'b0;
                    default: ;
                endcase
                if (ok) begin
                    for (k = 0; k < n; k++) begin
                        kept_q.push_back(t_out_item'{buf_b[pos + k], 1'b1, 1'b0});
                    end
                    pos += n;
                end else begin
                    pos++;
                end
            end
        end
        held_n = 0;
        if (!it.last_byte) begin
            for (k = pos; k < cnt && held_n < HOLD_DEPTH; k++) begin
                held_b[held_n] = buf_b[k];
                held_n++;
            end
        end else begin
            // The end of the stream is flagged on the final result, which is
            // a bare marker when nothing at all was kept.
            if (kept_q.size() == 0) begin
                kept_q.push_back(BARE_END);
            end else begin
                tail = kept_q.pop_back();
                tail.end_of_stream = 1'b1;
                kept_q.push_back(tail);
            end
        end
    endtask

    // Offers one byte, holds it until the block takes it, then records what
    // the block owes for it.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_kept(it);
        if (typed) begin
            pending_q.push_back(want);
        end else begin
            foreach (kept_q[k]) begin
                pending_q.push_back(kept_q[k]);
            end
        end
    endtask

    // Appends one character to stream_q: mostly valid UTF-8 of every length,
    // with raw noise bytes, truncated sequences and corrupted ones mixed in.
    task automatic add_char();
        logic [7:0] seq [4];
        int         pick, len, k;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            len = 1;
            k = $urandom_range(0, 9);
            if (k == 0) begin
                seq[0] = BYTE_TAB;
            end else if (k == 1) begin
                seq[0] = BYTE_LF;
            end else if (k == 2) begin
                seq[0] = BYTE_CR;
            end else begin
                seq[0] = 8'($urandom_range(8'h20, 8'h7F));
            end
        end else if (pick < 36) begin
            len = 1;
            seq[0] = 8'($urandom_range(0, 255));
        end else begin
            if (pick < 52) begin
                len = 2;
            end else if (pick < 70) begin
                len = 3;
            end else if (pick < 86) begin
                len = 4;
            end else begin
                len = $urandom_range(2, 4);
            end
            if (len == 2) begin
                seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
            end else if (len == 3) begin
                seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
            end else begin
                seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
            end
            for (k = 1; k < len; k++) begin
                seq[k] = 8'($urandom_range(8'h80, 8'hBF));
            end
            case (seq[0])
                LEAD_E0: seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
                LEAD_ED: seq[1] = 8'($urandom_range(8'h80, 8'h9F));
                LEAD_F0: seq[1] = 8'($urandom_range(8'h90, 8'hBF));
                LEAD_F4: seq[1] = 8'($urandom_range(8'h80, 8'h8F));
                default: ;
            endcase
            if (pick >= 93) begin
                // Corrupt it: a stray byte in the tail, or a lead whose range
                // rule the second byte may break.
                if (len == 2 || $urandom_range(0, 1) == 0) begin
                    seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
                end else begin
                    if (len == 3) begin
                        seq[0] = $urandom_range(0, 1) ? LEAD_E0 : LEAD_ED;
                    end else begin
                        seq[0] = $urandom_range(0, 1) ? LEAD_F0 : LEAD_F4;
                    end
                    seq[1] = 8'($urandom_range(8'h80, 8'hBF));
                end
            end else if (pick >= 86) begin
                len--;
            end
        end
        for (k = 0; k < len; k++) begin
            stream_q.push_back(seq[k]);
        end
    endtask

    // Builds a stream of n_chars characters and sends it, last flag on its
    // final byte.
    task automatic send_stream(input int n_chars, output int n_bytes);
        stream_q.delete();
        repeat (n_chars) add_char();
        foreach (stream_q[k]) begin
            send_item(t_in_item'{data_byte: stream_q[k],
                                 last_byte: 1'(k == stream_q.size() - 1)},
                      1'b0, NO_RESULT);
        end
        n_bytes = stream_q.size();
    endtask

    // Sender pause: nothing is offered until every owed result has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side. A hold-off request from the stimulus is counted down
    // here; otherwise the stall follows the stall rate of the phase.
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result checker and activity counter for the watchdog. Inputs are
    // driven by nonblocking assignments, so everything sampled here holds
    // the values from before this edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX) begin
                        $display("%0t: unexpected result byte=%h present=%b end=%b",
                                 $time, o_out_item.out_byte, o_out_item.byte_present,
                                 o_out_item.end_of_stream);
                    end
                end else begin
                    want = pending_q.pop_front();
                    if (o_out_item.out_byte !== want.out_byte ||
                        o_out_item.byte_present !== want.byte_present ||
                        o_out_item.end_of_stream !== want.end_of_stream) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX) begin
                            $write("%0t: mismatch expected byte=%h present=%b end=%b,",
                                   $time, want.out_byte, want.byte_present,
                                   want.end_of_stream);
                            $display(" got byte=%h present=%b end=%b",
                                     o_out_item.out_byte, o_out_item.byte_present,
                                     o_out_item.end_of_stream);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int sent, n_bytes;
        held_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner cases, back to back.
        for (int r = 0; r < DIR_N; r++) begin
            send_item(t_in_item'{DIR_TAB[r].data_byte, DIR_TAB[r].last_byte},
                      DIR_TAB[r].typed, DIR_TAB[r].want);
        end
        wait_drained();

        // Random streams: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 69; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 69; end
                default: begin send_pct = 19; stall_pct = 19; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_stream($urandom_range(1, 12), n_bytes);
                sent += n_bytes;
            end
            wait_drained();
        end

        // Long receiver hold-off while bytes keep coming, so the result
        // queue fills and the block pushes back on its input.
        send_pct  = 0;
        stall_pct = 0;
        hold_req  = HOLD_CYCLES;
        send_stream(12, n_bytes);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
